// ===== rtl/bigram_histogram_counter_unit_macros.svh =====
// assertion helpers for the file that checks itself
`ifndef BIGRAM_HISTOGRAM_COUNTER_UNIT_MACROS_SVH
`define BIGRAM_HISTOGRAM_COUNTER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define BHCU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define BHCU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bhc_pkg.sv =====
package bhc_pkg;

    localparam int MODE_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int INDEX_W    = 6;
    localparam int ENTRY_W    = 32;
    localparam int ACTIVE_W   = 12;
    localparam int IN_TDATA_W = 24;
    localparam int OUT_TDATA_W = 48;

    localparam int OPQ_DEPTH  = 4;
    localparam int OUTQ_DEPTH = 4;

    localparam logic [MODE_W-1:0] MODE_COUNT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [ACTIVE_W-1:0] ACTIVE_MAX = '1;

    localparam logic [BYTE_W-1:0] CHR_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHR_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CHR_CASE_OFS = 8'h20;
    localparam logic [BYTE_W-1:0] CHR_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CHR_LOWER_Z = 8'h7A;
    localparam logic [BYTE_W-1:0] CHR_LAT_LO_FIRST = 8'hE0;
    localparam logic [BYTE_W-1:0] CHR_LAT_LO_LAST  = 8'hF6;
    localparam logic [BYTE_W-1:0] CHR_LAT_HI_FIRST = 8'hF8;
    localparam logic [INDEX_W-1:0] IDX_LAT_LO_BASE = 6'd26;
    localparam logic [INDEX_W-1:0] IDX_LAT_HI_BASE = 6'd49;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_COUNT,
        OP_READ,
        OP_CLEAR
    } op_kind_t;

    typedef struct packed {
        logic               ok;
        logic [INDEX_W-1:0] idx;
    } letter_t;

    // entry_count sits in the lowest bits
    typedef struct packed {
        logic                pair_counted;
        logic [ACTIVE_W-1:0] active_pairs;
        logic [ENTRY_W-1:0]  entry_count;
    } result_t;

    function automatic letter_t letter_index(input logic [BYTE_W-1:0] b);
        letter_t r;
        logic [BYTE_W-1:0] lc;
        lc = (b >= CHR_UPPER_A && b <= CHR_UPPER_Z) ? b + CHR_CASE_OFS : b;
        r.ok = 1'b1;
        r.idx = '0;
        if (lc >= CHR_LOWER_A && lc <= CHR_LOWER_Z)
        begin
            r.idx = INDEX_W'(lc - CHR_LOWER_A);
        end
        else if (lc >= CHR_LAT_LO_FIRST && lc <= CHR_LAT_LO_LAST)
        begin
            r.idx = INDEX_W'(lc - CHR_LAT_LO_FIRST) + IDX_LAT_LO_BASE;
        end
        else if (lc >= CHR_LAT_HI_FIRST)
        begin
            r.idx = INDEX_W'(lc - CHR_LAT_HI_FIRST) + IDX_LAT_HI_BASE;
        end
        else
        begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== rtl/bhc_queue.sv =====
module bhc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty,
    output logic [CW-1:0]    level
);

    logic [WIDTH-1:0] slot [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] level_reg, level_next;

    assign full     = (level_reg == CW'(DEPTH));
    assign empty    = (level_reg == '0);
    assign level    = level_reg;
    assign pop_data = slot[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        level_next  = level_reg;
        if (push && !pop)
        begin
            level_next = level_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            level_next = level_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/bhc_front.sv =====
module bhc_front #(
    parameter int ALPHABET_SIZE = 57,
    localparam int AW = $clog2(ALPHABET_SIZE * ALPHABET_SIZE)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [bhc_pkg::MODE_W-1:0]   mode,
    input  logic [bhc_pkg::BYTE_W-1:0]   char_byte,
    input  logic [bhc_pkg::INDEX_W-1:0]  read_row,
    input  logic [bhc_pkg::INDEX_W-1:0]  read_col,
    input  logic                         busy,
    input  logic                         q_full,
    output logic                         op_push,
    output bhc_pkg::op_kind_t            op_kind,
    output logic [AW-1:0]                op_addr
);

    logic          prev_valid_reg, prev_valid_next;
    logic [AW-1:0] prev_base_reg, prev_base_next;
    bhc_pkg::letter_t li;
    logic          cur_ok;
    logic          accept;

    assign in_ready = !q_full && !busy;
    assign accept   = in_valid && in_ready;
    assign op_push  = accept;

    always_comb
    begin
        li     = bhc_pkg::letter_index(char_byte);
        cur_ok = li.ok && (li.idx < ALPHABET_SIZE);
        prev_valid_next = prev_valid_reg;
        prev_base_next  = prev_base_reg;
        op_kind = bhc_pkg::OP_NOP;
        op_addr = prev_base_reg + AW'(li.idx);
        case (mode)
            bhc_pkg::MODE_COUNT:
            begin
                if (cur_ok)
                begin
                    op_kind = prev_valid_reg ? bhc_pkg::OP_COUNT : bhc_pkg::OP_NOP;
                    prev_valid_next = 1'b1;
                    // row base of the next pair, kept so the add is all that is left
                    prev_base_next  = AW'(li.idx) * AW'(ALPHABET_SIZE);
                end
                else
                begin
                    prev_valid_next = 1'b0;
                end
            end
            bhc_pkg::MODE_READ:
            begin
                op_addr = AW'(read_row) * AW'(ALPHABET_SIZE) + AW'(read_col);
                if (read_row < ALPHABET_SIZE && read_col < ALPHABET_SIZE)
                begin
                    op_kind = bhc_pkg::OP_READ;
                end
            end
            bhc_pkg::MODE_CLEAR:
            begin
                op_kind = bhc_pkg::OP_CLEAR;
                prev_valid_next = 1'b0;
                prev_base_next  = '0;
            end
            default:
            begin
                op_kind = bhc_pkg::OP_NOP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_valid_reg <= 1'b0;
            prev_base_reg  <= '0;
        end
        else if (accept)
        begin
            prev_valid_reg <= prev_valid_next;
            prev_base_reg  <= prev_base_next;
        end
    end

endmodule

// ===== rtl/bhc_back.sv =====
module bhc_back #(
    parameter int ALPHABET_SIZE = 57,
    parameter int COUNT_WIDTH = 32,
    parameter int OUTQ_DEPTH = 4,
    localparam int DEPTH = ALPHABET_SIZE * ALPHABET_SIZE,
    localparam int AW = $clog2(DEPTH),
    localparam int LW = $clog2(OUTQ_DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 op_valid,
    input  bhc_pkg::op_kind_t    op_kind,
    input  logic [AW-1:0]        op_addr,
    output logic                 op_pop,
    input  logic [LW-1:0]        out_level,
    output logic                 out_push,
    output bhc_pkg::result_t     out_data,
    output logic                 busy
);

    localparam int TW = $clog2(DEPTH + 1);

    logic [COUNT_WIDTH-1:0] store [DEPTH];
    logic [COUNT_WIDTH-1:0] rdata_reg;

    logic              s1_v_reg, s1_v_next;
    bhc_pkg::op_kind_t s1_kind_reg;
    logic [AW-1:0]     s1_addr_reg;

    logic                   fwd_v_reg, fwd_v_next;
    logic [AW-1:0]          fwd_addr_reg, fwd_addr_next;
    logic [COUNT_WIDTH-1:0] fwd_data_reg, fwd_data_next;

    logic [TW-1:0] total_reg, total_next, total_upd;

    logic          clr_active_reg, clr_active_next;
    logic          clr_emit_reg, clr_emit_next;
    logic [AW-1:0] clr_idx_reg, clr_idx_next;
    logic          clr_last;

    logic                   blocked;
    logic                   room;
    logic [COUNT_WIDTH-1:0] cur;
    logic                   wr_en;
    logic [COUNT_WIDTH-1:0] wr_data;
    logic                   start_clear;

    assign busy     = clr_active_reg;
    assign clr_last = (clr_idx_reg == AW'(DEPTH - 1));
    assign blocked  = clr_active_reg || (s1_v_reg && s1_kind_reg == bhc_pkg::OP_CLEAR);
    // a slot in the result queue is held for every word in flight
    assign room     = ((LW + 1)'(out_level) + (LW + 1)'(s1_v_reg)) < (LW + 1)'(OUTQ_DEPTH);
    assign op_pop   = op_valid && !blocked && room;

    always_comb
    begin
        // the write issued on the edge that also read this entry is not in rdata yet
        cur = (fwd_v_reg && fwd_addr_reg == s1_addr_reg) ? fwd_data_reg : rdata_reg;
        wr_en       = 1'b0;
        wr_data     = cur + COUNT_WIDTH'(1);
        start_clear = 1'b0;
        total_upd   = total_reg;
        out_push    = 1'b0;
        out_data.entry_count  = '0;
        out_data.pair_counted = 1'b0;
        if (s1_v_reg)
        begin
            case (s1_kind_reg)
                bhc_pkg::OP_COUNT:
                begin
                    out_push = 1'b1;
                    out_data.pair_counted = 1'b1;
                    if (cur == '0)
                    begin
                        total_upd = total_reg + TW'(1);
                    end
                    wr_en = (cur != '1);
                end
                bhc_pkg::OP_READ:
                begin
                    out_push = 1'b1;
                    out_data.entry_count = bhc_pkg::ENTRY_W'(cur);
                end
                bhc_pkg::OP_CLEAR:
                begin
                    start_clear = 1'b1;
                end
                default:
                begin
                    out_push = 1'b1;
                end
            endcase
        end
        if (clr_active_reg && clr_last && clr_emit_reg)
        begin
            out_push = 1'b1;
        end
        out_data.active_pairs = (32'(total_upd) > 32'(bhc_pkg::ACTIVE_MAX)) ?
                                bhc_pkg::ACTIVE_MAX : bhc_pkg::ACTIVE_W'(total_upd);

        total_next = start_clear ? '0 : total_upd;
        s1_v_next  = op_pop;

        fwd_v_next    = fwd_v_reg;
        fwd_addr_next = fwd_addr_reg;
        fwd_data_next = fwd_data_reg;
        if (start_clear)
        begin
            fwd_v_next = 1'b0;
        end
        else if (wr_en)
        begin
            fwd_v_next    = 1'b1;
            fwd_addr_next = s1_addr_reg;
            fwd_data_next = wr_data;
        end

        clr_active_next = clr_active_reg;
        clr_emit_next   = clr_emit_reg;
        clr_idx_next    = clr_idx_reg;
        if (start_clear)
        begin
            clr_active_next = 1'b1;
            clr_emit_next   = 1'b1;
            clr_idx_next    = '0;
        end
        else if (clr_active_reg)
        begin
            if (clr_last)
            begin
                clr_active_next = 1'b0;
                clr_emit_next   = 1'b0;
            end
            else
            begin
                clr_idx_next = clr_idx_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg       <= 1'b0;
            s1_kind_reg    <= bhc_pkg::OP_NOP;
            s1_addr_reg    <= '0;
            fwd_v_reg      <= 1'b0;
            fwd_addr_reg   <= '0;
            fwd_data_reg   <= '0;
            total_reg      <= '0;
            // sweep the store once after reset
            clr_active_reg <= 1'b1;
            clr_emit_reg   <= 1'b0;
            clr_idx_reg    <= '0;
        end
        else
        begin
            s1_v_reg <= s1_v_next;
            if (op_pop)
            begin
                s1_kind_reg <= op_kind;
                s1_addr_reg <= op_addr;
            end
            fwd_v_reg      <= fwd_v_next;
            fwd_addr_reg   <= fwd_addr_next;
            fwd_data_reg   <= fwd_data_next;
            total_reg      <= total_next;
            clr_active_reg <= clr_active_next;
            clr_emit_reg   <= clr_emit_next;
            clr_idx_reg    <= clr_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            store[clr_idx_reg] <= '0;
        end
        else if (wr_en)
        begin
            store[s1_addr_reg] <= wr_data;
        end
        if (op_pop)
        begin
            rdata_reg <= store[op_addr];
        end
    end

endmodule

// ===== rtl/bigram_histogram_counter_unit.sv =====
// channel   dir  fields (lowest bit first)
// s_axis    in   tuser: mode[1:0]; tdata: char_byte, read_row, read_col
// m_axis    out  tdata: entry_count, active_pairs, pair_counted
//
// one word per cycle for count, read and idle modes while no sweep runs and the
// queues have room; a word passes the op queue and one pass through the store's
// read port on its way to the result queue; a clear word sweeps the store one
// entry per cycle, s_axis_tready is low for the whole sweep, and the clear's
// result is queued with the last entry; after reset the same sweep runs first
// a four-word result queue lets the input keep flowing while m_axis stalls
`include "bigram_histogram_counter_unit_macros.svh"

module bigram_histogram_counter_unit #(
    parameter int ALPHABET_SIZE = 57,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // char_byte[7:0], read_row[13:8], read_col[19:14], zero fill
    input  logic [bhc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // mode[1:0]
    input  logic [bhc_pkg::MODE_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // entry_count[31:0], active_pairs[43:32], pair_counted[44], zero fill
    output logic [bhc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    localparam int AW  = $clog2(ALPHABET_SIZE * ALPHABET_SIZE);
    localparam int KW  = $bits(bhc_pkg::op_kind_t);
    localparam int OPW = KW + AW;
    localparam int RW  = $bits(bhc_pkg::result_t);
    localparam int OLW = $clog2(bhc_pkg::OUTQ_DEPTH + 1);

    logic              op_push;
    bhc_pkg::op_kind_t fe_kind;
    logic [AW-1:0]     fe_addr;
    logic              op_full;
    logic              op_empty;
    logic              op_pop;
    logic [OPW-1:0]    op_q_data;
    bhc_pkg::op_kind_t be_kind;
    logic [AW-1:0]     be_addr;
    logic              back_busy;
    logic              clear_issue;

    logic              out_push;
    bhc_pkg::result_t  out_data;
    logic              out_full;
    logic              out_empty;
    logic              out_pop;
    logic [RW-1:0]     out_q_data;
    logic [OLW-1:0]    out_level;

    bhc_front #(
        .ALPHABET_SIZE(ALPHABET_SIZE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .mode      (s_axis_tuser),
        .char_byte (s_axis_tdata[7:0]),
        .read_row  (s_axis_tdata[13:8]),
        .read_col  (s_axis_tdata[19:14]),
        .busy      (back_busy),
        .q_full    (op_full),
        .op_push   (op_push),
        .op_kind   (fe_kind),
        .op_addr   (fe_addr)
    );

    bhc_queue #(
        .WIDTH(OPW),
        .DEPTH(bhc_pkg::OPQ_DEPTH)
    ) u_op_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (op_push),
        .push_data ({fe_kind, fe_addr}),
        .pop       (op_pop),
        .pop_data  (op_q_data),
        .full      (op_full),
        .empty     (op_empty),
        .level     ()
    );

    assign be_kind = bhc_pkg::op_kind_t'(op_q_data[OPW-1 -: KW]);
    assign be_addr = op_q_data[AW-1:0];

    bhc_back #(
        .ALPHABET_SIZE(ALPHABET_SIZE),
        .COUNT_WIDTH  (COUNT_WIDTH),
        .OUTQ_DEPTH   (bhc_pkg::OUTQ_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (!op_empty),
        .op_kind   (be_kind),
        .op_addr   (be_addr),
        .op_pop    (op_pop),
        .out_level (out_level),
        .out_push  (out_push),
        .out_data  (out_data),
        .busy      (back_busy)
    );

    bhc_queue #(
        .WIDTH(RW),
        .DEPTH(bhc_pkg::OUTQ_DEPTH)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (out_push),
        .push_data (out_data),
        .pop       (out_pop),
        .pop_data  (out_q_data),
        .full      (out_full),
        .empty     (out_empty),
        .level     (out_level)
    );

    assign m_axis_tvalid = !out_empty;
    assign out_pop       = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = bhc_pkg::OUT_TDATA_W'(out_q_data);

    assign clear_issue = op_pop && (be_kind == bhc_pkg::OP_CLEAR);

    `BHCU_ASSERT_IMP(a_op_queue_no_overflow, op_push, !op_full, "op queue overflow")
    `BHCU_ASSERT_IMP(a_out_queue_no_overflow, out_push, !out_full, "result queue overflow")
    `BHCU_ASSERT_IMP(a_no_issue_in_sweep, back_busy, !op_pop, "word issued during sweep")
    `BHCU_ASSERT_NEXT(a_clear_holds_issue, clear_issue, !op_pop, "word issued behind clear")

endmodule
